### rtl/cobc_pkg.sv
// Package for the circle versus oriented box collision block.
// Holds widths, word types, CORDIC constants and the register index codes; no dependencies.
package cobc_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int CFG_WIDTH       = 15;
  localparam int RADIUS_WIDTH    = 15;
  localparam int CORDIC_STEPS    = 20;
  localparam int GUARD_SHIFT     = 4;
  localparam int ZW              = 33;
  localparam int INV_GAIN        = 39797;

  typedef enum logic [0:0] {
    REG_HALF_LENGTH = 1'b0,
    REG_HALF_WIDTH  = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic signed [COORD_WIDTH_DEF-1:0] obstacle_x;
    logic signed [COORD_WIDTH_DEF-1:0] obstacle_y;
    logic [RADIUS_WIDTH-1:0]           obstacle_radius;
    logic signed [COORD_WIDTH_DEF-1:0] pose_x;
    logic signed [COORD_WIDTH_DEF-1:0] pose_y;
    logic [ANGLE_WIDTH_DEF-1:0]        heading;
  } query_t;

  typedef struct packed {
    logic collision;
    logic center_inside;
  } verdict_t;

  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] a;
    case (i)
      0: a = 32'h20000000;
      1: a = 32'h12E4051E;
      2: a = 32'h09FB385B;
      3: a = 32'h051111D4;
      4: a = 32'h028B0D43;
      5: a = 32'h0145D7E1;
      6: a = 32'h00A2F61E;
      7: a = 32'h00517C55;
      8: a = 32'h0028BE53;
      9: a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2FA;
      15: a = 32'h0000517D;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A30;
      19: a = 32'h00000518;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

endpackage

### rtl/cobc_stream_if.sv
// Valid/ready stream interface carrying one word of type word_t.
// Depends on nothing; the payload type is a parameter.
interface cobc_stream_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/circle_oriented_box_collision_top.sv
// Circle versus oriented box collision test, one obstacle/pose word per cycle
// while the output is not stalled. The pipeline holds 1 entry stage, 20 CORDIC
// stages and 3 judge stages, and an output stall holds the whole pipeline in place.
// Depends on cobc_pkg, cobc_stream_if, cobc_cordic and cobc_judge.
module circle_oriented_box_collision_top
  import cobc_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 cfg_we,
  input logic [0:0]           cfg_index,
  input logic [CFG_WIDTH-1:0] cfg_data,
  cobc_stream_if.sink         in_ch,
  cobc_stream_if.source       out_ch
);

  localparam int VW = COORD_WIDTH + GUARD_SHIFT + 3;

  logic [CFG_WIDTH-1:0] half_length, half_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_length <= CFG_WIDTH'(4096);
      half_width  <= CFG_WIDTH'(2048);
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_HALF_LENGTH: half_length <= cfg_data;
        REG_HALF_WIDTH:  half_width  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en = out_ch.ready || !out_ch.valid;
  assign in_ch.ready = en;

  logic signed [COORD_WIDTH:0] dx, dy;
  logic [31:0] theta;
  logic signed [ZW-1:0] z0;
  logic flip;
  assign dx = (COORD_WIDTH+1)'(in_ch.data.obstacle_x) - (COORD_WIDTH+1)'(in_ch.data.pose_x);
  assign dy = (COORD_WIDTH+1)'(in_ch.data.obstacle_y) - (COORD_WIDTH+1)'(in_ch.data.pose_y);
  assign theta = {in_ch.data.heading, (32-ANGLE_WIDTH)'(0)};
  always_comb begin
    z0 = ZW'($signed(32'(-theta)));
    flip = (z0 > ZW'(33'sh40000000)) || (z0 < -ZW'(33'sh40000000));
    if (flip) begin
      z0 = z0[ZW-1] ? z0 + ZW'(33'sh80000000) : z0 - ZW'(33'sh80000000);
    end
  end

  logic                    v0;
  logic signed [VW-1:0]    x0, y0;
  logic signed [ZW-1:0]    zr;
  logic [RADIUS_WIDTH-1:0] rpipe [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_ch.valid;
    end
    if (en) begin
      x0 <= flip ? -(VW'(dx) <<< GUARD_SHIFT) : VW'(dx) <<< GUARD_SHIFT;
      y0 <= flip ? -(VW'(dy) <<< GUARD_SHIFT) : VW'(dy) <<< GUARD_SHIFT;
      zr <= z0;
      rpipe[0] <= in_ch.data.obstacle_radius;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        rpipe[i+1] <= rpipe[i];
      end
    end
  end

  logic cv;
  logic signed [VW-1:0] cx, cy;
  cobc_cordic #(.VW(VW)) u_cordic (
    .clk, .rst, .en, .in_valid(v0), .in_x(x0), .in_y(y0), .in_z(zr),
    .out_valid(cv), .out_x(cx), .out_y(cy)
  );

  cobc_judge #(.VW(VW)) u_judge (
    .clk, .rst, .en, .in_valid(cv), .in_x(cx), .in_y(cy),
    .in_r(rpipe[CORDIC_STEPS]), .half_length, .half_width,
    .out_valid(out_ch.valid), .collision(out_ch.data.collision),
    .center_inside(out_ch.data.center_inside)
  );

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed under stall");
  a_inside: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.data.center_inside |-> out_ch.data.collision)
    else $error("inside without collision");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_ch.valid |-> in_ch.ready)
    else $error("stalled with empty output");
`endif

endmodule

### rtl/cobc_cordic.sv
// Pipelined CORDIC rotation stage: one micro-rotation per register stage.
// Depends on cobc_pkg.
module cobc_cordic
  import cobc_pkg::*;
#(
  parameter int VW = 22
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [VW-1:0] in_x,
  input  logic signed [VW-1:0] in_y,
  input  logic signed [ZW-1:0] in_z,
  output logic                 out_valid,
  output logic signed [VW-1:0] out_x,
  output logic signed [VW-1:0] out_y
);

  logic                 v [CORDIC_STEPS+1];
  logic signed [VW-1:0] x [CORDIC_STEPS+1];
  logic signed [VW-1:0] y [CORDIC_STEPS+1];
  logic signed [ZW-1:0] z [CORDIC_STEPS+1];

  assign v[0] = in_valid;
  assign x[0] = in_x;
  assign y[0] = in_y;
  assign z[0] = in_z;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [ZW-1:0] a;
    assign a = ZW'(atan_turn(i));
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
      if (en) begin
        if (!z[i][ZW-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - a;
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + a;
        end
      end
    end
  end

  assign out_valid = v[CORDIC_STEPS];
  assign out_x     = x[CORDIC_STEPS];
  assign out_y     = y[CORDIC_STEPS];

endmodule

### rtl/cobc_judge.sv
// Gain correction and box tests on the rotated center, three register stages.
// Depends on cobc_pkg.
module cobc_judge
  import cobc_pkg::*;
#(
  parameter int VW = 22
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [VW-1:0]    in_x,
  input  logic signed [VW-1:0]    in_y,
  input  logic [RADIUS_WIDTH-1:0] in_r,
  input  logic [CFG_WIDTH-1:0]    half_length,
  input  logic [CFG_WIDTH-1:0]    half_width,
  output logic                    out_valid,
  output logic                    collision,
  output logic                    center_inside
);

  localparam int PW = VW + 17;
  localparam int RW = VW + 1;
  localparam int DW = 20;
  localparam int SW = 2 * DW + 1;

  logic                    v1, v2, v3;
  logic signed [PW-1:0]    px, py;
  logic [RADIUS_WIDTH-1:0] r1, r2;
  logic signed [RW-1:0]    rx, ry;
  logic [RW-1:0]           ax, ay;
  logic [RW:0]             hl, hw, rr;
  logic                    ins2;
  logic                    okh, okv;
  logic [DW-1:0]           exh, eyh, exv, eyv;
  logic [SW-1:0]           sh, sv, r2sq;

  assign rx = RW'(px >>> 16);
  assign ry = RW'(py >>> 16);
  assign ax = rx[RW-1] ? RW'(-rx) : RW'(rx);
  assign ay = ry[RW-1] ? RW'(-ry) : RW'(ry);
  assign hl = (RW+1)'({half_length, 4'b0});
  assign hw = (RW+1)'({half_width, 4'b0});
  assign rr = (RW+1)'({r1, 4'b0});

  logic [RW:0] dxh, dyh, dxv, dyv;
  always_comb begin
    dxh = ({1'b0, ax} > hl) ? {1'b0, ax} - hl : '0;
    dyh = ({1'b0, ay} >= hw) ? {1'b0, ay} - hw : hw - {1'b0, ay};
    dxv = ({1'b0, ax} >= hl) ? {1'b0, ax} - hl : hl - {1'b0, ax};
    dyv = ({1'b0, ay} > hw) ? {1'b0, ay} - hw : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
    if (en) begin
      px   <= PW'(in_x) * PW'(INV_GAIN);
      py   <= PW'(in_y) * PW'(INV_GAIN);
      r1   <= in_r;
      ins2 <= ({1'b0, ax} <= hl) && ({1'b0, ay} <= hw);
      okh  <= (dxh <= rr) && (dyh <= rr);
      okv  <= (dxv <= rr) && (dyv <= rr);
      exh  <= DW'(dxh);
      eyh  <= DW'(dyh);
      exv  <= DW'(dxv);
      eyv  <= DW'(dyv);
      r2   <= r1;
      collision <= ins2 ||
        (okh && (sh <= r2sq)) || (okv && (sv <= r2sq));
      center_inside <= ins2;
    end
  end

  assign sh   = (SW'(exh) * SW'(exh)) + (SW'(eyh) * SW'(eyh));
  assign sv   = (SW'(exv) * SW'(exv)) + (SW'(eyv) * SW'(eyv));
  assign r2sq = SW'({r2, 4'b0}) * SW'({r2, 4'b0});
  assign out_valid = v3;

endmodule
